### rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants for the bitmap page-frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int FRAME_COUNT_DEF = 4096;

  localparam logic [2:0] CMD_ALLOC      = 3'd0;
  localparam logic [2:0] CMD_ALLOC_RUN  = 3'd1;
  localparam logic [2:0] CMD_FREE       = 3'd2;
  localparam logic [2:0] CMD_MARK_FREE  = 3'd3;
  localparam logic [2:0] CMD_MARK_USED  = 3'd4;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE    = 2'd1;
  localparam logic [1:0] STAT_DOUBLE_FREE = 2'd2;
  localparam logic [1:0] STAT_UNSUPPORTED = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] frame;
    logic [12:0] range_end;
    logic [9:0]  groups;
    logic        high_memory;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] frame_out;
    logic [12:0] free_frames;
  } out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLEAR,
    OP_SCAN_INIT,
    OP_NEXT,
    OP_ONE_HIT,
    OP_RUN_HIT,
    OP_RUN_RETRY,
    OP_RUN_FOUND,
    OP_FREE_ADDR,
    OP_FREE_SETUP,
    OP_MARK_SETUP,
    OP_RANGE_START,
    OP_WRITE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic        set_status;
    logic [1:0]  status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       high;
    logic       groups_zero;
    logic       in_map;
    logic       wp_end;
    logic       clear_last;
    logic       word_zero;
    logic       one_zero;
    logic       cand_ok;
    logic       chk_ok;
    logic       last_word;
    logic       lo_zero;
    logic       bit_set;
    logic       mark_empty;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_CHK_RD,
    S_CHK_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_RANGE_START,
    S_RMW_RD,
    S_RMW_WR,
    S_FINISH
  } state_t;

endpackage

### rtl/bpfa_dp.sv
// ----------------------------------------------------------------------------
// bpfa_dp
// Datapath: free-frame bitmap memory, search hint, free count, range masks.
// ----------------------------------------------------------------------------
module bpfa_dp #(
  parameter int FRAME_COUNT = bpfa_pkg::FRAME_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bpfa_pkg::in_t      in_data,
  input  bpfa_pkg::dp_cmd_t  dcmd,
  output bpfa_pkg::dp_stat_t dstat,
  output bpfa_pkg::out_t     out_data
);

  localparam int NWORDS = FRAME_COUNT / 32;
  localparam int NFRAMES = NWORDS * 32;
  localparam int NBYTES = NWORDS * 4;
  localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int WPW = AW + 1;
  localparam int HW = AW + 2;
  localparam int XW = AW + 16;
  localparam int CW = $clog2(NFRAMES + 1);
  localparam logic [XW-1:0] NFRAMES_X = XW'(NFRAMES);
  localparam logic [XW-1:0] NBYTES_X = XW'(NBYTES);
  localparam logic [WPW-1:0] NWORDS_W = WPW'(NWORDS);

  logic [31:0]     mem [NWORDS];
  logic [31:0]     rdata;
  bpfa_pkg::in_t   item;
  logic [WPW-1:0]  wp;
  logic [WPW-1:0]  sw;
  logic [XW-1:0]   lo;
  logic [XW-1:0]   hi;
  logic            set_op;
  logic            moved;
  logic [HW-1:0]   hint;
  logic [CW-1:0]   count;
  logic [1:0]      status_r;
  logic [11:0]     fout_r;

  logic [AW-1:0]   addr;
  logic [XW-1:0]   wpx;
  logic [XW-1:0]   him1;
  logic [31:0]     mask;
  logic [4:0]      jbit;
  logic [1:0]      obyte;
  logic            has_ff;
  logic [XW-1:0]   s_byte;
  logic [XW-1:0]   frame_x;
  logic [XW-1:0]   b_byte;
  logic [XW-1:0]   b_end;
  logic [XW-1:0]   mark_end;
  logic [XW-1:0]   k_len;
  logic [XW-1:0]   cnt_x;
  logic [XW-1:0]   cnt_add;
  logic [XW-1:0]   cnt_new;

  assign addr = wp[AW-1:0];
  assign wpx = XW'(wp);
  assign him1 = hi - XW'(1);

  always_comb begin
    mask = '1;
    if (wpx == (lo >> 5)) begin
      mask = mask & ({32{1'b1}} << lo[4:0]);
    end
    if (wpx == (him1 >> 5)) begin
      mask = mask & ({32{1'b1}} >> (5'd31 - him1[4:0]));
    end
  end

  // Lowest set bit of the word just read.
  always_comb begin
    jbit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (rdata[i]) begin
        jbit = 5'(i);
      end
    end
  end

  // First all-ones byte of the word just read.
  always_comb begin
    obyte = 2'd0;
    has_ff = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (rdata[8*i +: 8] == 8'hff) begin
        obyte = 2'(i);
        has_ff = 1'b1;
      end
    end
  end

  assign s_byte = (wpx << 2) + XW'(obyte);
  assign frame_x = XW'(item.frame);
  assign b_byte = frame_x >> 3;
  assign b_end = (b_byte + XW'(item.groups) > NBYTES_X) ? NBYTES_X
               : b_byte + XW'(item.groups);
  assign mark_end = (XW'(item.range_end) > NFRAMES_X) ? NFRAMES_X
                  : XW'(item.range_end);

  assign k_len = hi - lo;
  assign cnt_x = XW'(count);
  assign cnt_add = cnt_x + k_len;
  always_comb begin
    if (set_op) begin
      cnt_new = (cnt_add > NFRAMES_X) ? NFRAMES_X : cnt_add;
    end else begin
      cnt_new = (cnt_x < k_len) ? '0 : cnt_x - k_len;
    end
  end

  always_comb begin
    dstat.cmd = item.cmd;
    dstat.high = item.high_memory;
    dstat.groups_zero = (item.groups == '0);
    dstat.in_map = (frame_x < NFRAMES_X);
    dstat.wp_end = (wp == NWORDS_W);
    dstat.clear_last = (wp == NWORDS_W - WPW'(1));
    dstat.word_zero = (rdata == '0);
    dstat.one_zero = (wp == '0) && rdata[0];
    dstat.cand_ok = has_ff && (s_byte + XW'(item.groups) <= NBYTES_X);
    dstat.chk_ok = ((rdata & mask) == mask);
    dstat.last_word = (wpx == (him1 >> 5));
    dstat.lo_zero = (lo == '0);
    dstat.bit_set = rdata[item.frame[4:0]];
    dstat.mark_empty = !(frame_x < mark_end);
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (dcmd.op == bpfa_pkg::OP_CLEAR) begin
      mem[addr] <= '0;
    end else if (dcmd.op == bpfa_pkg::OP_WRITE) begin
      mem[addr] <= set_op ? (rdata | mask) : (rdata & ~mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      hint <= '0;
      count <= '0;
      moved <= 1'b0;
    end else begin
      unique case (dcmd.op) inside
        bpfa_pkg::OP_CLEAR, bpfa_pkg::OP_NEXT, bpfa_pkg::OP_WRITE: begin
          wp <= wp + WPW'(1);
        end
        bpfa_pkg::OP_LOAD: begin
          fout_r <= '0;
        end
        bpfa_pkg::OP_SCAN_INIT: begin
          wp <= WPW'(hint >> 2);
          moved <= 1'b0;
        end
        bpfa_pkg::OP_ONE_HIT: begin
          hint <= {addr, 2'b00};
          lo <= (wpx << 5) + XW'(jbit);
          hi <= (wpx << 5) + XW'(jbit) + XW'(1);
          set_op <= 1'b0;
          fout_r <= 12'((wpx << 5) + XW'(jbit));
        end
        bpfa_pkg::OP_RUN_HIT: begin
          if (!moved) begin
            hint <= {addr, 2'b00};
            moved <= 1'b1;
          end
          if (dstat.cand_ok) begin
            lo <= s_byte << 3;
            hi <= (s_byte + XW'(item.groups)) << 3;
            sw <= wp;
          end else begin
            wp <= wp + WPW'(1);
          end
        end
        bpfa_pkg::OP_RUN_RETRY: begin
          wp <= sw + WPW'(1);
        end
        bpfa_pkg::OP_RUN_FOUND: begin
          set_op <= 1'b0;
          fout_r <= lo[11:0];
        end
        bpfa_pkg::OP_FREE_ADDR: begin
          wp <= WPW'(frame_x >> 5);
        end
        bpfa_pkg::OP_FREE_SETUP: begin
          set_op <= 1'b1;
          if (item.groups == '0) begin
            lo <= frame_x;
            hi <= frame_x + XW'(1);
          end else begin
            lo <= b_byte << 3;
            hi <= b_end << 3;
          end
          if (b_byte < XW'(hint)) begin
            hint <= HW'(b_byte);
          end
        end
        bpfa_pkg::OP_MARK_SETUP: begin
          hint <= '0;
          lo <= frame_x;
          hi <= mark_end;
          set_op <= (item.cmd == bpfa_pkg::CMD_MARK_FREE);
        end
        bpfa_pkg::OP_RANGE_START: begin
          count <= CW'(cnt_new);
          wp <= WPW'(lo >> 5);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.op == bpfa_pkg::OP_LOAD) begin
      item <= in_data;
    end
    if (dcmd.op == bpfa_pkg::OP_LOAD) begin
      status_r <= bpfa_pkg::STAT_OK;
    end else if (dcmd.set_status) begin
      status_r <= dcmd.status;
    end
    if (dcmd.op == bpfa_pkg::OP_EMIT) begin
      out_data.status <= status_r;
      out_data.frame_out <= fout_r;
      out_data.free_frames <= 13'(cnt_x);
    end
  end

endmodule

### rtl/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Controller: sequences scans, run checks and read-modify-write passes.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bpfa_pkg::dp_stat_t dstat,
  output bpfa_pkg::dp_cmd_t  dcmd
);

  bpfa_pkg::state_t state;
  bpfa_pkg::state_t state_next;
  logic             emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpfa_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    dcmd.op = bpfa_pkg::OP_NOP;
    dcmd.set_status = 1'b0;
    dcmd.status = bpfa_pkg::STAT_OK;
    in_ready = 1'b0;
    emit = 1'b0;
    unique case (state)
      bpfa_pkg::S_CLEAR: begin
        dcmd.op = bpfa_pkg::OP_CLEAR;
        if (dstat.clear_last) begin
          state_next = bpfa_pkg::S_IDLE;
        end
      end
      bpfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dcmd.op = bpfa_pkg::OP_LOAD;
          state_next = bpfa_pkg::S_DISPATCH;
        end
      end
      bpfa_pkg::S_DISPATCH: begin
        state_next = bpfa_pkg::S_FINISH;
        case (dstat.cmd) inside
          bpfa_pkg::CMD_ALLOC, bpfa_pkg::CMD_ALLOC_RUN: begin
            if (dstat.high) begin
              dcmd.set_status = 1'b1;
              dcmd.status = bpfa_pkg::STAT_UNSUPPORTED;
            end else if (dstat.cmd == bpfa_pkg::CMD_ALLOC_RUN && dstat.groups_zero) begin
              dcmd.set_status = 1'b1;
              dcmd.status = bpfa_pkg::STAT_NO_SPACE;
            end else begin
              dcmd.op = bpfa_pkg::OP_SCAN_INIT;
              state_next = bpfa_pkg::S_SCAN_RD;
            end
          end
          bpfa_pkg::CMD_FREE: begin
            if (dstat.in_map) begin
              dcmd.op = bpfa_pkg::OP_FREE_ADDR;
              state_next = bpfa_pkg::S_FREE_RD;
            end
          end
          bpfa_pkg::CMD_MARK_FREE, bpfa_pkg::CMD_MARK_USED: begin
            dcmd.op = bpfa_pkg::OP_MARK_SETUP;
            if (!dstat.mark_empty) begin
              state_next = bpfa_pkg::S_RANGE_START;
            end
          end
          default: begin
            dcmd.set_status = 1'b1;
            dcmd.status = bpfa_pkg::STAT_UNSUPPORTED;
          end
        endcase
      end
      bpfa_pkg::S_SCAN_RD: begin
        if (dstat.wp_end) begin
          dcmd.set_status = 1'b1;
          dcmd.status = bpfa_pkg::STAT_NO_SPACE;
          state_next = bpfa_pkg::S_FINISH;
        end else begin
          state_next = bpfa_pkg::S_SCAN_CHK;
        end
      end
      bpfa_pkg::S_SCAN_CHK: begin
        if (dstat.word_zero) begin
          dcmd.op = bpfa_pkg::OP_NEXT;
          state_next = bpfa_pkg::S_SCAN_RD;
        end else if (dstat.cmd == bpfa_pkg::CMD_ALLOC) begin
          dcmd.op = bpfa_pkg::OP_ONE_HIT;
          if (dstat.one_zero) begin
            // Frame zero is never handed out; the hint move still stands.
            dcmd.set_status = 1'b1;
            dcmd.status = bpfa_pkg::STAT_NO_SPACE;
            state_next = bpfa_pkg::S_FINISH;
          end else begin
            state_next = bpfa_pkg::S_RANGE_START;
          end
        end else begin
          dcmd.op = bpfa_pkg::OP_RUN_HIT;
          state_next = dstat.cand_ok ? bpfa_pkg::S_CHK_RD : bpfa_pkg::S_SCAN_RD;
        end
      end
      bpfa_pkg::S_CHK_RD: begin
        state_next = bpfa_pkg::S_CHK_CHK;
      end
      bpfa_pkg::S_CHK_CHK: begin
        if (!dstat.chk_ok) begin
          dcmd.op = bpfa_pkg::OP_RUN_RETRY;
          state_next = bpfa_pkg::S_SCAN_RD;
        end else if (!dstat.last_word) begin
          dcmd.op = bpfa_pkg::OP_NEXT;
          state_next = bpfa_pkg::S_CHK_RD;
        end else if (dstat.lo_zero) begin
          dcmd.set_status = 1'b1;
          dcmd.status = bpfa_pkg::STAT_NO_SPACE;
          state_next = bpfa_pkg::S_FINISH;
        end else begin
          dcmd.op = bpfa_pkg::OP_RUN_FOUND;
          state_next = bpfa_pkg::S_RANGE_START;
        end
      end
      bpfa_pkg::S_FREE_RD: begin
        state_next = bpfa_pkg::S_FREE_CHK;
      end
      bpfa_pkg::S_FREE_CHK: begin
        if (dstat.bit_set) begin
          dcmd.set_status = 1'b1;
          dcmd.status = bpfa_pkg::STAT_DOUBLE_FREE;
          state_next = bpfa_pkg::S_FINISH;
        end else begin
          dcmd.op = bpfa_pkg::OP_FREE_SETUP;
          state_next = bpfa_pkg::S_RANGE_START;
        end
      end
      bpfa_pkg::S_RANGE_START: begin
        dcmd.op = bpfa_pkg::OP_RANGE_START;
        state_next = bpfa_pkg::S_RMW_RD;
      end
      bpfa_pkg::S_RMW_RD: begin
        state_next = bpfa_pkg::S_RMW_WR;
      end
      bpfa_pkg::S_RMW_WR: begin
        dcmd.op = bpfa_pkg::OP_WRITE;
        state_next = dstat.last_word ? bpfa_pkg::S_FINISH : bpfa_pkg::S_RMW_RD;
      end
      bpfa_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          dcmd.op = bpfa_pkg::OP_EMIT;
          emit = 1'b1;
          state_next = bpfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bpfa_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == bpfa_pkg::S_DISPATCH))
    else $error("accepted item did not move to dispatch");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("result not presented after emit");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !emit)
    else $error("result overwritten while still waiting");

  a_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == bpfa_pkg::S_RMW_WR) |-> ($past(state) == bpfa_pkg::S_RMW_RD))
    else $error("bitmap write without a fresh read");

endmodule

### rtl/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page-frame allocator over a one-bit-per-frame free bitmap.
// ----------------------------------------------------------------------------
//  Channel  Signals                       Direction  Payload
//  in       in_valid, in_ready, in_data   input      cmd, frame, range_end,
//                                                    groups, high_memory
//  out      out_valid, out_ready, out_data output    status, frame_out,
//                                                    free_frames
//
//  One item at a time. Bitmap words go through a single read/write memory
//  port: each word visited is read in one state and checked or rewritten
//  in the next. After reset a clearing pass zeroes the bitmap before the
//  first item is taken. A finished result waits in the output register
//  while the next item is accepted.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
  parameter int FRAME_COUNT = bpfa_pkg::FRAME_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bpfa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bpfa_pkg::out_t out_data
);

  bpfa_pkg::dp_cmd_t  dcmd;
  bpfa_pkg::dp_stat_t dstat;

  bpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dstat     (dstat),
    .dcmd      (dcmd)
  );

  bpfa_dp #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .dcmd     (dcmd),
    .dstat    (dstat),
    .out_data (out_data)
  );

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the bitmap page-frame allocator one item at a time. A clocked
// predictor keeps its own free bitmap, search hint and free count and works
// out each result when its command is accepted. Results are compared in order.
// Directed commands come first, then weighted random traffic. Both sides idle
// at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWORDS = 128;
  localparam int NBYTES = NWORDS * 4;
  localparam int NFRAMES = NWORDS * 32;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  bpfa_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  bpfa_pkg::out_t out_data;

  bitmap_page_frame_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state.
  logic [31:0] frame_map [NWORDS];
  int          hint_byte;
  int          avail_count;

  bpfa_pkg::in_t  pending_cmds [$];
  bpfa_pkg::out_t expected_results [$];
  int   errors;
  int   cmd_seen [8];
  int   status_seen [4];
  bit   calm;
  bit   in_taken;
  bit   out_taken;
  int   in_gap;
  int   out_stall;
  int   stall_draw;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] map_byte(int b);
    return frame_map[b >> 2][(b & 3) * 8 +: 8];
  endfunction

  function automatic void count_add(int k);
    avail_count = (avail_count + k > NFRAMES) ? NFRAMES : avail_count + k;
  endfunction

  function automatic void count_sub(int k);
    avail_count = (avail_count < k) ? 0 : avail_count - k;
  endfunction

  function automatic bit find_first_frame(output int found);
    found = 0;
    for (int w = hint_byte >> 2; w < NWORDS; w++) begin
      if (frame_map[w] != 32'h0) begin
        hint_byte = w * 4;
        for (int j = 0; j < 32; j++) begin
          if (frame_map[w][j]) begin
            found = w * 32 + j;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Only the first all-ones byte of each word is a candidate start, and only
  // the first word with any free bit moves the hint.
  function automatic bit find_free_run(int n, output int start);
    bit moved;
    bit ok;
    int o;
    int s;
    moved = 1'b0;
    start = 0;
    for (int w = hint_byte >> 2; w < NWORDS; w++) begin
      if (frame_map[w] == 32'h0) continue;
      if (!moved) begin
        moved = 1'b1;
        hint_byte = w * 4;
      end
      o = 4;
      for (int i = 0; i < 4; i++) begin
        if (frame_map[w][i * 8 +: 8] == 8'hff) begin
          o = i;
          break;
        end
      end
      if (o == 4) continue;
      s = w * 4 + o;
      ok = (s + n <= NBYTES);
      for (int k = 0; ok && k < n; k++)
        if (map_byte(s + k) != 8'hff) ok = 1'b0;
      if (ok) begin
        start = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bpfa_pkg::out_t predict_allocation(bpfa_pkg::in_t c);
    bpfa_pkg::out_t r;
    int   f;
    int   b;
    int   e;
    r.status = bpfa_pkg::STAT_OK;
    r.frame_out = '0;
    case (c.cmd)
      bpfa_pkg::CMD_ALLOC: begin
        if (c.high_memory) r.status = bpfa_pkg::STAT_UNSUPPORTED;
        else if (!find_first_frame(f) || f == 0) r.status = bpfa_pkg::STAT_NO_SPACE;
        else begin
          frame_map[f >> 5][f & 31] = 1'b0;
          count_sub(1);
          r.frame_out = f[11:0];
        end
      end
      bpfa_pkg::CMD_ALLOC_RUN: begin
        if (c.high_memory) r.status = bpfa_pkg::STAT_UNSUPPORTED;
        else if (c.groups == 0) r.status = bpfa_pkg::STAT_NO_SPACE;
        else if (!find_free_run(int'(c.groups), f) || f == 0)
          r.status = bpfa_pkg::STAT_NO_SPACE;
        else begin
          for (int k = 0; k < int'(c.groups); k++) begin
            frame_map[(f + k) >> 2][((f + k) & 3) * 8 +: 8] = 8'h00;
            count_sub(8);
          end
          r.frame_out = 12'(f * 8);
        end
      end
      bpfa_pkg::CMD_FREE: begin
        b = int'(c.frame) >> 3;
        if (frame_map[c.frame >> 5][c.frame & 31]) r.status = bpfa_pkg::STAT_DOUBLE_FREE;
        else begin
          if (c.groups == 0) begin
            frame_map[c.frame >> 5][c.frame & 31] = 1'b1;
            count_add(1);
          end else begin
            for (int k = 0; k < int'(c.groups) && b + k < NBYTES; k++) begin
              frame_map[(b + k) >> 2][((b + k) & 3) * 8 +: 8] = 8'hff;
              count_add(8);
            end
          end
          if (b < hint_byte) hint_byte = b;
        end
      end
      bpfa_pkg::CMD_MARK_FREE, bpfa_pkg::CMD_MARK_USED: begin
        e = (int'(c.range_end) > NFRAMES) ? NFRAMES : int'(c.range_end);
        hint_byte = 0;
        for (int i = int'(c.frame); i < e; i++) begin
          frame_map[i >> 5][i & 31] = (c.cmd == bpfa_pkg::CMD_MARK_FREE);
          if (c.cmd == bpfa_pkg::CMD_MARK_FREE) count_add(1);
          else count_sub(1);
        end
      end
      default: r.status = bpfa_pkg::STAT_UNSUPPORTED;
    endcase
    r.free_frames = 13'(avail_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Monitor and predictor: results are checked before the new item is added.
  always @(posedge clk) begin
    bpfa_pkg::out_t want;
    in_taken <= in_valid && in_ready && !rst;
    out_taken <= out_valid && out_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.status, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.frame_out != want.frame_out)
          report_mismatch("frame_out", out_data.frame_out, want.frame_out);
        if (out_data.free_frames != want.free_frames)
          report_mismatch("free_frames", out_data.free_frames, want.free_frames);
        status_seen[out_data.status]++;
      end
    end
    if (!rst && in_valid && in_ready) begin
      cmd_seen[in_data.cmd]++;
      expected_results.push_back(predict_allocation(in_data));
    end
  end

  // Sender: holds each item until accepted, then waits its drawn gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_cmds.size() > 0) begin
      in_data <= pending_cmds.pop_front();
      in_valid <= 1'b1;
      in_gap <= calm ? 0 : $urandom_range(0, 6);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: after each result taken, stalls for a random draw unless calm.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_taken && !calm) begin
      stall_draw = $urandom_range(0, 6);
      out_ready <= (stall_draw == 0);
      out_stall <= (stall_draw > 0) ? stall_draw - 1 : 0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic bpfa_pkg::in_t make_cmd(logic [2:0] cmd, int frame, int range_end,
                                             int groups, bit high);
    bpfa_pkg::in_t c;
    c.cmd = cmd;
    c.frame = 12'(frame);
    c.range_end = 13'(range_end);
    c.groups = 10'(groups);
    c.high_memory = high;
    return c;
  endfunction

  function automatic bpfa_pkg::in_t random_cmd();
    int            pick;
    int            f;
    bpfa_pkg::in_t c;
    pick = $urandom_range(0, 99);
    f = $urandom_range(0, 4095);
    c = make_cmd(bpfa_pkg::CMD_ALLOC, f, 0, 0, ($urandom_range(0, 19) == 0));
    c.range_end = 13'($urandom);
    c.groups = 10'($urandom);
    if (pick < 30) begin
      c.cmd = bpfa_pkg::CMD_ALLOC;
    end else if (pick < 50) begin
      c.cmd = bpfa_pkg::CMD_ALLOC_RUN;
      if ($urandom_range(0, 49) != 0) c.groups = 10'($urandom_range(0, 8));
    end else if (pick < 75) begin
      c.cmd = bpfa_pkg::CMD_FREE;
      if ($urandom_range(0, 2) != 0) c.groups = 0;
      else if ($urandom_range(0, 9) != 0) begin
        c.groups = 10'($urandom_range(1, 6));
        c.frame = 12'(f & ~7);
      end
    end else if (pick < 97) begin
      c.cmd = (pick < 88) ? bpfa_pkg::CMD_MARK_FREE : bpfa_pkg::CMD_MARK_USED;
      case ($urandom_range(0, 9))
        0: begin
          c.frame = 12'($urandom_range(0, 3));
          c.range_end = 13'(NFRAMES);
        end
        1, 2: ;
        default: c.range_end = 13'(f + $urandom_range(0, 300));
      endcase
    end else begin
      c.cmd = 3'($urandom_range(5, 7));
    end
    return c;
  endfunction

  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    errors = 0;
    calm = 1'b0;
    in_gap = 0;
    out_stall = 0;
    hint_byte = 0;
    avail_count = 0;
    for (int w = 0; w < NWORDS; w++) frame_map[w] = 32'h0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty map, then frame zero reachable, then the usual cases.
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC_RUN, 0, 0, 1, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_MARK_FREE, 0, NFRAMES, 0, 1));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC_RUN, 0, 0, 2, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_MARK_USED, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC_RUN, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC_RUN, 0, 0, 4, 1));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC_RUN, 0, 0, 4, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_FREE, 100, 0, 0, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_FREE, 1, 0, 0, 1));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_FREE, 8, 0, 2, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_MARK_USED, 0, 8191, 0, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_FREE, 4095, 0, 1023, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC_RUN, 0, 0, 1, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_MARK_FREE, 4000, 100, 0, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_MARK_FREE, 8, NFRAMES, 0, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC_RUN, 0, 0, 511, 0));
    pending_cmds.push_back(make_cmd(bpfa_pkg::CMD_ALLOC_RUN, 0, 0, 1023, 0));
    pending_cmds.push_back(make_cmd(3'd5, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(3'd6, 4095, 8191, 1023, 1));
    pending_cmds.push_back(make_cmd(3'd7, 0, 0, 0, 0));
    wait_drained();

    // Random traffic in blocks, some blocks without any idling.
    for (int blk = 0; blk < 21; blk++) begin
      calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 50; i++) pending_cmds.push_back(random_cmd());
      if (blk == 10) wait_drained();
      else
        while (pending_cmds.size() > 10) @(negedge clk);
    end
    calm = 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);

    $display("Commands: alloc %0d, run %0d, free %0d, mark free %0d, mark used %0d, other %0d",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4],
             cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
    $display("Statuses: ok %0d, no space %0d, double free %0d, unsupported %0d, mismatches %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("bitmap_page_frame_allocator regression: pass");
    end else begin
      $display("bitmap_page_frame_allocator regression: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("bitmap_page_frame_allocator regression: fail");
    $finish;
  end

endmodule
